FILE: src/knn_pkg.sv
// ----------------------------------------------------------------------------
// knn_pkg
// Shared constants, codes and controller/datapath interface types for the
// k-nearest-neighbor table.
// ----------------------------------------------------------------------------
package knn_pkg;

	localparam int MAX_POINTS_DEF = 256;
	localparam int MAX_K_DEF      = 16;
	localparam int COORD_BITS_DEF = 16;

	// fixed field widths of the ports
	localparam int CMD_W      = 2;
	localparam int IN_COORD_W = 16;
	localparam int IDX_W      = 8;
	localparam int RANK_W     = 4;
	localparam int OUT_DIST_W = 34;
	localparam int STAT_W     = 2;
	localparam int KREG_W     = 5;

	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
	localparam logic [CMD_W-1:0] CMD_ADD   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

	localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FULL     = 2'd1;
	localparam logic [STAT_W-1:0] STAT_UNLOADED = 2'd2;

	localparam logic [KREG_W-1:0] KREG_RESET = 5'd16;

	// register index 0: neighbours in use
	localparam logic REG_K = 1'b0;

	typedef struct packed {
		logic start;    // latch the accepted word
		logic clr;      // empty the store
		logic pt_wr;    // store new point, begin walk
		logic pt_rd;    // read stored point i and its fill
		logic sq;       // per-axis squares
		logic sum;      // squared distance
		logic sc_clr;   // slot counter to zero
		logic ld;       // stream list i into the buffer
		logic ins;      // insert into both lists
		logic wb;       // write back list i
		logic fl;       // write list of the new point
		logic fin;      // commit new point
		logic rd_iss;   // read one list entry
		logic res_load; // load output register
	} knn_cmd_t;

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic             full;
		logic             more;
		logic             slot_end;
		logic             slot_last;
	} knn_sts_t;

endpackage

FILE: src/knn_ins.sv
// ----------------------------------------------------------------------------
// knn_ins
// Sorted-list insertion: places one candidate into a buffered top-K list
// with a strict less-than rule and shift down.
// ----------------------------------------------------------------------------
module knn_ins #(
	parameter int MAX_K = 16,
	parameter int DW    = 34,
	parameter int PW    = 8,
	parameter int FW    = 5
) (
	input  logic [MAX_K-1:0][DW-1:0] cur_d,
	input  logic [MAX_K-1:0][PW-1:0] ids,
	input  logic [FW-1:0]            fill,
	input  logic [FW-1:0]            k,
	input  logic [DW-1:0]            cand_d,
	input  logic [PW-1:0]            cand_id,
	output logic [MAX_K-1:0][DW-1:0] dist_new,
	output logic [MAX_K-1:0][PW-1:0] ids_new,
	output logic [FW-1:0]            fill_new,
	output logic                     hit
);

	logic [FW-1:0]            f;
	logic [FW-1:0]            h;
	logic [FW-1:0]            r;
	logic [MAX_K-1:0][DW-1:0] sh_d;
	logic [MAX_K-1:0][PW-1:0] sh_id;

	always_comb begin
		f = (fill > k) ? k : fill;
		h = f;
		for (int j = MAX_K - 1; j >= 0; j--) begin
			if (FW'(j) < f && cand_d < cur_d[j]) begin
				h = FW'(j);
			end
		end
		hit = (h < k);
		r = (f < k) ? f : k - FW'(1);
	end

	always_comb begin
		sh_d[0]  = cur_d[0];
		sh_id[0] = ids[0];
		for (int j = 1; j < MAX_K; j++) begin
			sh_d[j]  = cur_d[j-1];
			sh_id[j] = ids[j-1];
		end
	end

	always_comb begin
		for (int j = 0; j < MAX_K; j++) begin
			if (!hit || FW'(j) < h || FW'(j) > r) begin
				dist_new[j] = cur_d[j];
				ids_new[j]  = ids[j];
			end else if (FW'(j) == h) begin
				dist_new[j] = cand_d;
				ids_new[j]  = cand_id;
			end else begin
				dist_new[j] = sh_d[j];
				ids_new[j]  = sh_id[j];
			end
		end
		if (!hit) begin
			fill_new = fill;
		end else if (f < k) begin
			fill_new = f + FW'(1);
		end else begin
			fill_new = f;
		end
	end

endmodule

FILE: src/knn_dp.sv
// ----------------------------------------------------------------------------
// knn_dp
// Datapath: point store, neighbor list memory, fill counts, distance
// pipeline, list buffers and the result register.
// ----------------------------------------------------------------------------
module knn_dp #(
	parameter int MAX_POINTS = 256,
	parameter int MAX_K      = 16,
	parameter int COORD_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  knn_pkg::knn_cmd_t             cmd,
	output knn_pkg::knn_sts_t             sts,
	input  logic [knn_pkg::CMD_W-1:0]      command,
	input  logic [knn_pkg::IN_COORD_W-1:0] x_coord,
	input  logic [knn_pkg::IN_COORD_W-1:0] y_coord,
	input  logic [knn_pkg::IN_COORD_W-1:0] z_coord,
	input  logic [knn_pkg::IDX_W-1:0]      point_index,
	input  logic [knn_pkg::RANK_W-1:0]     rank,
	input  logic [knn_pkg::KREG_W-1:0]     k_cfg,
	output logic [knn_pkg::IDX_W-1:0]      neighbor_index,
	output logic [knn_pkg::OUT_DIST_W-1:0] squared_distance,
	output logic                          found,
	output logic [knn_pkg::IDX_W-1:0]      new_index,
	output logic [knn_pkg::STAT_W-1:0]     status
);
	import knn_pkg::*;

	localparam int CB  = COORD_BITS;
	localparam int SQW = 2 * CB;
	localparam int DW  = 2 * CB + 2;
	localparam int PW  = $clog2(MAX_POINTS);
	localparam int CW  = $clog2(MAX_POINTS + 1);
	localparam int KW  = (MAX_K > 1) ? $clog2(MAX_K) : 1;
	localparam int SW  = $clog2(MAX_K + 1);
	localparam int FW  = SW;
	localparam int NE  = MAX_POINTS * MAX_K;
	localparam int AW  = $clog2(NE);
	localparam int EW  = PW + DW;

	logic [CMD_W-1:0]  cmd_q;
	logic [CB-1:0]     x_q, y_q, z_q;
	logic [IDX_W-1:0]  p_q;
	logic [RANK_W-1:0] rank_q;
	logic [FW-1:0]     k_q;
	logic [FW-1:0]     k_c;
	logic              add_ok_q;

	logic [CW-1:0] count_q;
	logic [PW-1:0] n_q;
	logic [PW-1:0] i_q;
	logic [SW-1:0] sc_q;

	logic [3*CB-1:0] pt_mem [MAX_POINTS];
	logic [3*CB-1:0] pt_rd_q;
	logic [FW-1:0]   fill_mem [MAX_POINTS];
	logic [FW-1:0]   fill_rd_q;
	logic [EW-1:0]   nbr_mem [NE];
	logic [EW-1:0]   nbr_rd_q;

	logic [SQW-1:0] sqx_s1, sqy_s1, sqz_s1;
	logic [DW-1:0]  d_s2;
	logic [CB-1:0]  px, py, pz, dx, dy, dz;

	logic [MAX_K-1:0][DW-1:0] lb_d, nb_d, lb_d_new, nb_d_new;
	logic [MAX_K-1:0][PW-1:0] lb_id, nb_id, lb_id_new, nb_id_new;
	logic [FW-1:0]            nb_fill_q, lfill_new, nfill_new;
	logic                     lhit, nhit;

	logic [AW-1:0] base_i, base_n, base_p, rd_addr, wr_addr;
	logic [EW-1:0] wr_data;
	logic          nbr_we, nbr_re;
	logic [FW-1:0] fill_eff;
	logic [KW-1:0] slot;

	always_comb begin
		if (k_cfg == '0) begin
			k_c = FW'(1);
		end else if (32'(k_cfg) > 32'(MAX_K)) begin
			k_c = FW'(MAX_K);
		end else begin
			k_c = FW'(k_cfg);
		end
	end

	// add_ok_q marks an add that stored its point (the count may read full by then)
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			cmd_q    <= command;
			x_q      <= CB'(x_coord);
			y_q      <= CB'(y_coord);
			z_q      <= CB'(z_coord);
			p_q      <= point_index;
			rank_q   <= rank;
			k_q      <= k_c;
			add_ok_q <= 1'b0;
		end else if (cmd.pt_wr) begin
			add_ok_q <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			n_q     <= '0;
			i_q     <= '0;
			sc_q    <= '0;
		end else begin
			if (cmd.clr) begin
				count_q <= '0;
			end else if (cmd.fin) begin
				count_q <= count_q + CW'(1);
			end
			if (cmd.pt_wr) begin
				n_q <= PW'(count_q);
				i_q <= '0;
			end else if (cmd.wb && sts.slot_last) begin
				i_q <= i_q + PW'(1);
			end
			if (cmd.sc_clr) begin
				sc_q <= '0;
			end else if (cmd.ld || cmd.wb || cmd.fl) begin
				sc_q <= sc_q + SW'(1);
			end
		end
	end

	assign sts.cmd       = cmd_q;
	assign sts.full      = (count_q == CW'(MAX_POINTS));
	assign sts.more      = (i_q < n_q);
	assign sts.slot_end  = (sc_q == SW'(MAX_K));
	assign sts.slot_last = (sc_q == SW'(MAX_K - 1));

	// point store
	always_ff @(posedge clk) begin
		if (cmd.pt_wr) begin
			pt_mem[PW'(count_q)] <= {x_q, y_q, z_q};
		end
		if (cmd.pt_rd) begin
			pt_rd_q <= pt_mem[i_q];
		end
	end

	// fill counts
	always_ff @(posedge clk) begin
		if (cmd.ins && lhit) begin
			fill_mem[i_q] <= lfill_new;
		end else if (cmd.fin) begin
			fill_mem[n_q] <= nb_fill_q;
		end
		if (cmd.pt_rd) begin
			fill_rd_q <= fill_mem[i_q];
		end else if (cmd.rd_iss) begin
			fill_rd_q <= fill_mem[PW'(p_q)];
		end
	end

	// distance: abs diff and square, then sum
	assign px = pt_rd_q[3*CB-1:2*CB];
	assign py = pt_rd_q[2*CB-1:CB];
	assign pz = pt_rd_q[CB-1:0];
	assign dx = (x_q >= px) ? x_q - px : px - x_q;
	assign dy = (y_q >= py) ? y_q - py : py - y_q;
	assign dz = (z_q >= pz) ? z_q - pz : pz - z_q;

	always_ff @(posedge clk) begin
		if (cmd.sq) begin
			sqx_s1 <= SQW'(dx) * SQW'(dx);
			sqy_s1 <= SQW'(dy) * SQW'(dy);
			sqz_s1 <= SQW'(dz) * SQW'(dz);
		end
		if (cmd.sum) begin
			d_s2 <= DW'(sqx_s1) + DW'(sqy_s1) + DW'(sqz_s1);
		end
	end

	// neighbor list memory, one read and one write port
	assign base_i = AW'(i_q) * AW'(MAX_K);
	assign base_n = AW'(n_q) * AW'(MAX_K);
	assign base_p = AW'(PW'(p_q)) * AW'(MAX_K);
	assign slot   = KW'(rank_q);

	always_comb begin
		rd_addr = base_i + AW'(sc_q);
		nbr_re  = cmd.ld && !sts.slot_end;
		if (cmd.rd_iss) begin
			rd_addr = base_p + AW'(slot);
			nbr_re  = 1'b1;
		end
		nbr_we = cmd.wb || cmd.fl;
		if (cmd.fl) begin
			wr_addr = base_n + AW'(sc_q);
			wr_data = {nb_id[KW'(sc_q)], nb_d[KW'(sc_q)]};
		end else begin
			wr_addr = base_i + AW'(sc_q);
			wr_data = {lb_id[KW'(sc_q)], lb_d[KW'(sc_q)]};
		end
	end

	always_ff @(posedge clk) begin
		if (nbr_we) begin
			nbr_mem[wr_addr] <= wr_data;
		end
		if (nbr_re) begin
			nbr_rd_q <= nbr_mem[rd_addr];
		end
	end

	knn_ins #(.MAX_K(MAX_K), .DW(DW), .PW(PW), .FW(FW)) u_ins_l (
		.cur_d(lb_d), .ids(lb_id), .fill(fill_rd_q), .k(k_q),
		.cand_d(d_s2), .cand_id(n_q),
		.dist_new(lb_d_new), .ids_new(lb_id_new), .fill_new(lfill_new), .hit(lhit)
	);

	knn_ins #(.MAX_K(MAX_K), .DW(DW), .PW(PW), .FW(FW)) u_ins_n (
		.cur_d(nb_d), .ids(nb_id), .fill(nb_fill_q), .k(k_q),
		.cand_d(d_s2), .cand_id(i_q),
		.dist_new(nb_d_new), .ids_new(nb_id_new), .fill_new(nfill_new), .hit(nhit)
	);

	// list buffers
	always_ff @(posedge clk) begin
		if (cmd.ld && sc_q != '0) begin
			lb_id[KW'(sc_q - SW'(1))] <= nbr_rd_q[EW-1:DW];
			lb_d[KW'(sc_q - SW'(1))]  <= nbr_rd_q[DW-1:0];
		end else if (cmd.ins) begin
			lb_id <= lb_id_new;
			lb_d  <= lb_d_new;
		end
		if (cmd.pt_wr) begin
			nb_fill_q <= '0;
		end else if (cmd.ins && nhit) begin
			nb_d      <= nb_d_new;
			nb_id     <= nb_id_new;
			nb_fill_q <= nfill_new;
		end
	end

	// result register
	assign fill_eff = (fill_rd_q > k_q) ? k_q : fill_rd_q;

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			neighbor_index   <= '0;
			squared_distance <= '0;
			found            <= 1'b0;
			new_index        <= '0;
			status           <= STAT_OK;
			case (cmd_q)
				CMD_ADD: begin
					if (!add_ok_q) begin
						status <= STAT_FULL;
					end else begin
						new_index <= IDX_W'(n_q);
					end
				end
				CMD_READ: begin
					if (32'(p_q) >= 32'(count_q)) begin
						status <= STAT_UNLOADED;
					end else if (32'(rank_q) < 32'(fill_eff)) begin
						neighbor_index   <= IDX_W'(nbr_rd_q[EW-1:DW]);
						squared_distance <= OUT_DIST_W'(nbr_rd_q[DW-1:0]);
						found            <= 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

FILE: src/knn_ctrl.sv
// ----------------------------------------------------------------------------
// knn_ctrl
// Controller state machine: sequences clears, the add walk, list reads and the
// output handshake.
// ----------------------------------------------------------------------------
module knn_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  knn_pkg::knn_sts_t sts,
	output knn_pkg::knn_cmd_t cmd
);
	import knn_pkg::*;

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_DEC    = 4'd1;
	localparam logic [3:0] S_NEXT   = 4'd2;
	localparam logic [3:0] S_SQ     = 4'd3;
	localparam logic [3:0] S_SUM    = 4'd4;
	localparam logic [3:0] S_LOAD   = 4'd5;
	localparam logic [3:0] S_INS    = 4'd6;
	localparam logic [3:0] S_WB     = 4'd7;
	localparam logic [3:0] S_FLUSH  = 4'd8;
	localparam logic [3:0] S_FIN    = 4'd9;
	localparam logic [3:0] S_RDWAIT = 4'd10;
	localparam logic [3:0] S_DONE   = 4'd11;

	logic [3:0] state_q, state_d;
	logic       out_valid_q;
	logic       out_free;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.start = 1'b1;
					state_d   = S_DEC;
				end
			end
			S_DEC: begin
				case (sts.cmd)
					CMD_CLEAR: begin
						cmd.clr = 1'b1;
						state_d = S_DONE;
					end
					CMD_ADD: begin
						if (sts.full) begin
							state_d = S_DONE;
						end else begin
							cmd.pt_wr = 1'b1;
							state_d   = S_NEXT;
						end
					end
					CMD_READ: begin
						cmd.rd_iss = 1'b1;
						state_d    = S_RDWAIT;
					end
					default: begin
						state_d = S_DONE;
					end
				endcase
			end
			S_NEXT: begin
				cmd.sc_clr = 1'b1;
				if (sts.more) begin
					cmd.pt_rd = 1'b1;
					state_d   = S_SQ;
				end else begin
					state_d = S_FLUSH;
				end
			end
			S_SQ: begin
				cmd.sq  = 1'b1;
				state_d = S_SUM;
			end
			S_SUM: begin
				cmd.sum = 1'b1;
				state_d = S_LOAD;
			end
			S_LOAD: begin
				cmd.ld = 1'b1;
				if (sts.slot_end) begin
					state_d = S_INS;
				end
			end
			S_INS: begin
				cmd.ins    = 1'b1;
				cmd.sc_clr = 1'b1;
				state_d    = S_WB;
			end
			S_WB: begin
				cmd.wb = 1'b1;
				if (sts.slot_last) begin
					state_d = S_NEXT;
				end
			end
			S_FLUSH: begin
				cmd.fl = 1'b1;
				if (sts.slot_last) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				cmd.fin = 1'b1;
				state_d = S_DONE;
			end
			S_RDWAIT: begin
				state_d = S_DONE;
			end
			S_DONE: begin
				if (out_free) begin
					cmd.res_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// one word in flight at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("accepted a word while busy");

	a_result_shown: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_load |=> out_valid)
		else $error("result loaded but not presented");

	a_list_port_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.ld, cmd.wb, cmd.fl, cmd.rd_iss}))
		else $error("list memory port claimed twice");

	a_no_load_while_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !cmd.res_load)
		else $error("result overwritten while held");

endmodule

FILE: src/k_nearest_neighbor_table.sv
// ----------------------------------------------------------------------------
// k_nearest_neighbor_table
// Brute-force K-nearest-neighbor table over 3-D points, one word at a time.
// ----------------------------------------------------------------------------
// Items are handled one at a time. Adding point n walks the n stored points;
// each one takes a point read, the square and sum stages, streaming its list
// out of the list memory, one insertion step and writing the list back; the
// add ends by writing the new point's own list. No clearing pass runs after
// reset. A finished result sits in the output register while the next
// word is taken. neighbours_in_use lives at byte address 0.
// ----------------------------------------------------------------------------
module k_nearest_neighbor_table #(
	parameter int MAX_POINTS = knn_pkg::MAX_POINTS_DEF,
	parameter int MAX_K      = knn_pkg::MAX_K_DEF,
	parameter int COORD_BITS = knn_pkg::COORD_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [2:0]                    paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [knn_pkg::CMD_W-1:0]      command,
	input  logic [knn_pkg::IN_COORD_W-1:0] x_coord,
	input  logic [knn_pkg::IN_COORD_W-1:0] y_coord,
	input  logic [knn_pkg::IN_COORD_W-1:0] z_coord,
	input  logic [knn_pkg::IDX_W-1:0]      point_index,
	input  logic [knn_pkg::RANK_W-1:0]     rank,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [knn_pkg::IDX_W-1:0]      neighbor_index,
	output logic [knn_pkg::OUT_DIST_W-1:0] squared_distance,
	output logic                          found,
	output logic [knn_pkg::IDX_W-1:0]      new_index,
	output logic [knn_pkg::STAT_W-1:0]     status
);
	import knn_pkg::*;

	logic [KREG_W-1:0] k_reg_q;
	knn_cmd_t          cmd;
	knn_sts_t          sts;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_reg_q <= KREG_RESET;
		end else if (psel && penable && pwrite && paddr[2] == REG_K) begin
			k_reg_q <= pwdata[KREG_W-1:0];
		end
	end

	assign prdata = (paddr[2] == REG_K) ? 32'(k_reg_q) : '0;

	knn_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready),
		.sts(sts), .cmd(cmd)
	);

	knn_dp #(.MAX_POINTS(MAX_POINTS), .MAX_K(MAX_K), .COORD_BITS(COORD_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.command(command), .x_coord(x_coord), .y_coord(y_coord), .z_coord(z_coord),
		.point_index(point_index), .rank(rank), .k_cfg(k_reg_q),
		.neighbor_index(neighbor_index), .squared_distance(squared_distance),
		.found(found), .new_index(new_index), .status(status)
	);

endmodule
